// ===== hw/rtl/swarq_pkg.sv =====
// Package for the sliding-window ARQ endpoint: sizes, codes and controller states.
// Used by the controller, the datapath and the top level; depends on nothing.
package swarq_pkg;
  localparam int WINDOW_DEF = 10;
  localparam int SEND_DEPTH_DEF = 16;
  localparam int TIME_BITS_DEF = 16;
  localparam logic [7:0] TIMEOUT_RESET = 8'd2;

  localparam logic [2:0] OP_DATA = 3'd0;
  localparam logic [2:0] OP_ACK = 3'd1;
  localparam logic [2:0] OP_TICK = 3'd2;
  localparam logic [2:0] OP_ENQ = 3'd3;
  localparam logic [2:0] OP_CONSUME = 3'd4;

  localparam logic [1:0] KIND_DATA = 2'd0;
  localparam logic [1:0] KIND_ACK = 2'd1;
  localparam logic [1:0] KIND_STATUS = 2'd2;

  localparam logic [2:0] ST_OK = 3'd0;
  localparam logic [2:0] ST_ORDER = 3'd1;
  localparam logic [2:0] ST_RXFULL = 3'd2;
  localparam logic [2:0] ST_TXFULL = 3'd3;
  localparam logic [2:0] ST_RXEMPTY = 3'd4;
  localparam logic [2:0] ST_IDLE = 3'd5;

  typedef enum logic [3:0] {
    S_IDLE, S_SIMPLE, S_ACK_MARK, S_ACK_MIN, S_ACK_FIN,
    S_RETX, S_NEW, S_TICK_END, S_CONS_ACK
  } state_t;

  typedef struct packed {
    logic load;
    logic simple;
    logic ack_mark;
    logic ack_min;
    logic ack_fin;
    logic retx;
    logic new_send;
    logic tick_end;
    logic cons_ack;
    logic scan_clr;
  } cmd_t;

  typedef struct packed {
    logic scan_done;
    logic new_more;
    logic cons_flag;
    logic [2:0] op;
  } stat_t;
endpackage

// ===== hw/rtl/sliding_window_arq_endpoint.sv =====
// Top level of the sliding-window ARQ endpoint: controller plus datapath.
// An ACK and a tick scan the send slots at one slot per cycle, and a tick then sends
// new frames; a consume that frees a full receive window also sends an ACK. A new beat
// is taken only once busy has fallen after the last one. The receiver cannot stall.
// Reset (rst_n low, synchronous) restores all sequence state and the timeout register.
module sliding_window_arq_endpoint #(
  parameter int WINDOW = swarq_pkg::WINDOW_DEF,
  parameter int SEND_DEPTH = swarq_pkg::SEND_DEPTH_DEF,
  parameter int TIME_BITS = swarq_pkg::TIME_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  input  logic [2:0] in_op,
  input  logic [7:0] in_frame_seq,
  input  logic [7:0] in_acked_upto,
  input  logic [7:0] in_advertised_window,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [7:0] cfg_data,
  output logic       out_valid,
  output logic [1:0] out_kind,
  output logic [7:0] out_tx_seq,
  output logic [3:0] out_slot,
  output logic [7:0] out_ack_last,
  output logic [4:0] out_ack_window,
  output logic [3:0] out_buffer_index,
  output logic [2:0] out_status,
  output logic       out_last
);
  import swarq_pkg::*;

  cmd_t cmd;
  stat_t stat;
  logic busy_c;
  logic start_ok;
  logic v_d, l_d;
  logic [1:0] k_d;
  logic [7:0] ts_d, al_d;
  logic [3:0] si_d, bi_d;
  logic [4:0] aw_d;
  logic [2:0] st_d;
  logic h_v_r, h_l_r;
  logic [1:0] h_k_r;
  logic [7:0] h_ts_r, h_al_r;
  logic [3:0] h_si_r, h_bi_r;
  logic [4:0] h_aw_r;
  logic [2:0] h_st_r;
  logic end_r;

  assign cfg_ready = 1'b1;
  assign start_ok = start && !busy;

  swarq_ctrl u_ctrl (.clk, .rst_n, .start(start_ok), .stat, .busy(busy_c), .cmd);

  swarq_dp #(.WINDOW(WINDOW), .SEND_DEPTH(SEND_DEPTH), .TIME_BITS(TIME_BITS)) u_dp (
    .clk, .rst_n, .cmd, .stat, .in_op, .in_frame_seq, .in_acked_upto,
    .in_advertised_window, .cfg_we(cfg_valid), .cfg_data,
    .out_valid(v_d), .out_kind(k_d), .out_tx_seq(ts_d), .out_slot(si_d),
    .out_ack_last(al_d), .out_ack_window(aw_d), .out_buffer_index(bi_d),
    .out_status(st_d), .out_last(l_d)
  );

  // One result is held back so that the last data frame of a tick can be flagged.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      h_v_r <= 1'b0;
      end_r <= 1'b0;
    end else begin
      end_r <= cmd.tick_end;
      if (v_d || end_r || h_l_r) h_v_r <= v_d;
      if (v_d) begin
        h_k_r <= k_d; h_ts_r <= ts_d; h_si_r <= si_d; h_al_r <= al_d;
        h_aw_r <= aw_d; h_bi_r <= bi_d; h_st_r <= st_d; h_l_r <= l_d;
      end
    end
  end

  assign out_valid = h_v_r && (v_d || end_r || h_l_r);
  assign out_kind = h_k_r;
  assign out_tx_seq = h_ts_r;
  assign out_slot = h_si_r;
  assign out_ack_last = h_al_r;
  assign out_ack_window = h_aw_r;
  assign out_buffer_index = h_bi_r;
  assign out_status = h_st_r;
  assign out_last = h_l_r || (end_r && !v_d);
  assign busy = busy_c || end_r || (h_v_r && !h_l_r);
endmodule

// ===== hw/rtl/swarq_ctrl.sv =====
// Controller state machine of the ARQ endpoint: sequences slot scans and results.
// Depends on swarq_pkg; drives the datapath through cmd_t and reads stat_t.
module swarq_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  swarq_pkg::stat_t  stat,
  output logic              busy,
  output swarq_pkg::cmd_t   cmd
);
  import swarq_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          unique case (stat.op)
            OP_ACK: state_nxt = S_ACK_MARK;
            OP_TICK: state_nxt = S_RETX;
            default: state_nxt = S_SIMPLE;
          endcase
        end
      end
      S_SIMPLE: state_nxt = stat.cons_flag ? S_CONS_ACK : S_IDLE;
      S_CONS_ACK: state_nxt = S_IDLE;
      S_ACK_MARK: if (stat.scan_done) state_nxt = S_ACK_MIN;
      S_ACK_MIN: if (stat.scan_done) state_nxt = S_ACK_FIN;
      S_ACK_FIN: state_nxt = S_IDLE;
      S_RETX: if (stat.scan_done) state_nxt = S_NEW;
      S_NEW: if (!stat.new_more) state_nxt = S_TICK_END;
      S_TICK_END: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    busy = (state_r != S_IDLE);
    unique case (state_r)
      S_IDLE: begin
        cmd.load = start;
        cmd.scan_clr = 1'b1;
      end
      S_SIMPLE: cmd.simple = 1'b1;
      S_CONS_ACK: cmd.cons_ack = 1'b1;
      S_ACK_MARK: begin
        cmd.ack_mark = 1'b1;
        cmd.scan_clr = stat.scan_done;
      end
      S_ACK_MIN: cmd.ack_min = 1'b1;
      S_ACK_FIN: cmd.ack_fin = 1'b1;
      S_RETX: begin
        cmd.retx = 1'b1;
        cmd.scan_clr = stat.scan_done;
      end
      S_NEW: cmd.new_send = 1'b1;
      S_TICK_END: cmd.tick_end = 1'b1;
      default: cmd = '0;
    endcase
  end
endmodule

// ===== hw/rtl/swarq_dp.sv =====
// Datapath of the ARQ endpoint: connection state, send slots, scan counter, results.
// Depends on swarq_pkg; commanded by swarq_ctrl.
module swarq_dp #(
  parameter int WINDOW = swarq_pkg::WINDOW_DEF,
  parameter int SEND_DEPTH = swarq_pkg::SEND_DEPTH_DEF,
  parameter int TIME_BITS = swarq_pkg::TIME_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  swarq_pkg::cmd_t  cmd,
  output swarq_pkg::stat_t stat,
  input  logic [2:0]       in_op,
  input  logic [7:0]       in_frame_seq,
  input  logic [7:0]       in_acked_upto,
  input  logic [7:0]       in_advertised_window,
  input  logic             cfg_we,
  input  logic [7:0]       cfg_data,
  output logic             out_valid,
  output logic [1:0]       out_kind,
  output logic [7:0]       out_tx_seq,
  output logic [3:0]       out_slot,
  output logic [7:0]       out_ack_last,
  output logic [4:0]       out_ack_window,
  output logic [3:0]       out_buffer_index,
  output logic [2:0]       out_status,
  output logic             out_last
);
  import swarq_pkg::*;

  localparam int SW = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int QW = $clog2(SEND_DEPTH);
  localparam logic [4:0] WIN5 = 5'(WINDOW);
  localparam logic [4:0] DEPTH5 = 5'(SEND_DEPTH);
  localparam logic [SW-1:0] LAST_SLOT = SW'(WINDOW - 1);
  localparam logic [QW-1:0] LAST_Q = QW'(SEND_DEPTH - 1);

  logic [7:0] tmo_r;
  logic [2:0] op_r;
  logic [7:0] fseq_r, aupto_r, awin_r;
  logic [7:0] exp_r, base_r, nseq_r;
  logic [4:0] rxc_r, peer_r, txc_r;
  logic rxflag_r;
  logic [QW-1:0] head_r;
  logic [TIME_BITS-1:0] tick_r;
  logic [7:0] sseq_r [WINDOW];
  logic [WINDOW-1:0] sent_r, acked_r;
  logic [TIME_BITS-1:0] stime_r [WINDOW];
  logic [SW-1:0] j_r;
  logic found_r;
  logic [7:0] best_r;
  logic any_r;

  logic [7:0] outst, upto, dj;
  logic live_j, freef;
  logic [SW-1:0] free_idx;
  logic [TIME_BITS-1:0] age;
  logic [4:0] qsum, qidx;

  assign outst = nseq_r - base_r;
  assign upto = aupto_r + 8'd1 - base_r;
  assign dj = sseq_r[j_r] - base_r;
  assign live_j = sent_r[j_r] && !acked_r[j_r];
  assign age = tick_r - stime_r[j_r];
  assign qsum = 5'(head_r) + txc_r;
  assign qidx = (qsum >= DEPTH5) ? qsum - DEPTH5 : qsum;

  always_comb begin
    freef = 1'b0;
    free_idx = '0;
    for (int k = WINDOW - 1; k >= 0; k--) begin
      if (!sent_r[k] || acked_r[k]) begin
        freef = 1'b1;
        free_idx = SW'(k);
      end
    end
  end

  assign stat.scan_done = (j_r == LAST_SLOT);
  assign stat.new_more = (outst < {3'd0, peer_r}) && (txc_r != 5'd0) && freef;
  assign stat.cons_flag = (op_r == OP_CONSUME) && (rxc_r != 5'd0) && rxflag_r;
  assign stat.op = cmd.load ? in_op : op_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tmo_r <= TIMEOUT_RESET;
      exp_r <= 8'd1;
      base_r <= 8'd1;
      nseq_r <= 8'd1;
      rxc_r <= '0;
      rxflag_r <= 1'b0;
      peer_r <= WIN5;
      txc_r <= '0;
      head_r <= '0;
      tick_r <= '0;
      sent_r <= '0;
      acked_r <= '0;
      j_r <= '0;
      out_valid <= 1'b0;
      for (int k = 0; k < WINDOW; k++) begin
        sseq_r[k] <= '0;
        stime_r[k] <= '0;
      end
    end else begin
      out_valid <= 1'b0;
      if (cfg_we) tmo_r <= cfg_data;
      if (cmd.scan_clr) j_r <= '0;
      else if (cmd.ack_mark || cmd.ack_min || cmd.retx) j_r <= j_r + SW'(1);
      if (cmd.load) begin
        op_r <= in_op;
        fseq_r <= in_frame_seq;
        aupto_r <= in_acked_upto;
        awin_r <= in_advertised_window;
        found_r <= 1'b0;
        best_r <= '0;
        any_r <= 1'b0;
        if (in_op == OP_TICK) tick_r <= tick_r + TIME_BITS'(1);
      end
      if (cmd.simple || cmd.cons_ack || cmd.ack_fin || cmd.tick_end ||
          (cmd.retx && live_j && age >= TIME_BITS'(tmo_r)) ||
          (cmd.new_send && stat.new_more)) begin
        out_valid <= 1'b1;
      end
      out_kind <= KIND_STATUS;
      out_tx_seq <= '0;
      out_slot <= '0;
      out_ack_last <= '0;
      out_ack_window <= '0;
      out_buffer_index <= '0;
      out_status <= ST_OK;
      out_last <= 1'b1;
      if (cmd.simple) begin
        unique case (op_r)
          OP_DATA: begin
            if (fseq_r != exp_r) begin
              out_status <= ST_ORDER;
            end else if (rxc_r >= WIN5) begin
              rxflag_r <= 1'b1;
              out_status <= ST_RXFULL;
            end else begin
              rxc_r <= rxc_r + 5'd1;
              exp_r <= exp_r + 8'd1;
              out_kind <= KIND_ACK;
              out_ack_last <= exp_r;
              out_ack_window <= WIN5 - rxc_r - 5'd1;
              out_buffer_index <= rxc_r[3:0];
            end
          end
          OP_ENQ: begin
            if (txc_r >= DEPTH5) begin
              out_status <= ST_TXFULL;
            end else begin
              txc_r <= txc_r + 5'd1;
              out_buffer_index <= qidx[3:0];
            end
          end
          OP_CONSUME: begin
            if (rxc_r == 5'd0) begin
              out_status <= ST_RXEMPTY;
            end else begin
              rxc_r <= rxc_r - 5'd1;
              out_last <= !rxflag_r;
            end
          end
          default: out_status <= ST_IDLE;
        endcase
      end
      if (cmd.cons_ack) begin
        rxflag_r <= 1'b0;
        out_kind <= KIND_ACK;
        out_ack_last <= exp_r - 8'd1;
        out_ack_window <= WIN5 - rxc_r;
      end
      if (cmd.ack_mark) begin
        if (j_r == '0) peer_r <= (awin_r > 8'(WINDOW)) ? WIN5 : awin_r[4:0];
        if (upto <= outst && live_j && dj < upto && dj < outst) acked_r[j_r] <= 1'b1;
      end
      if (cmd.ack_min && live_j && dj < outst && (!found_r || dj < best_r)) begin
        found_r <= 1'b1;
        best_r <= dj;
      end
      if (cmd.ack_fin) begin
        base_r <= found_r ? base_r + best_r : nseq_r;
      end
      if (cmd.retx) begin
        out_kind <= KIND_DATA;
        out_tx_seq <= sseq_r[j_r];
        out_slot <= 4'(j_r);
        out_last <= 1'b0;
        if (live_j && age >= TIME_BITS'(tmo_r)) begin
          stime_r[j_r] <= tick_r;
          any_r <= 1'b1;
        end
      end
      if (cmd.new_send && stat.new_more) begin
        sseq_r[free_idx] <= nseq_r;
        sent_r[free_idx] <= 1'b1;
        acked_r[free_idx] <= 1'b0;
        stime_r[free_idx] <= tick_r;
        out_kind <= KIND_DATA;
        out_tx_seq <= nseq_r;
        out_slot <= 4'(free_idx);
        out_buffer_index <= 4'(head_r);
        out_last <= 1'b0;
        head_r <= (head_r == LAST_Q) ? '0 : head_r + QW'(1);
        txc_r <= txc_r - 5'd1;
        nseq_r <= nseq_r + 8'd1;
        any_r <= 1'b1;
      end
      if (cmd.tick_end) begin
        out_status <= ST_IDLE;
        if (any_r) begin
          out_valid <= 1'b0;
        end
      end
    end
  end

  // The final result of a tick that sent frames is flagged by retiming: see top level.
endmodule

// ===== hw/rtl/swarq_checker.sv =====
// Port-level checker for the ARQ endpoint, bound to the top level.
// Depends on swarq_pkg for result codes.
module swarq_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       start,
  input logic       busy,
  input logic       out_valid,
  input logic [1:0] out_kind,
  input logic [2:0] out_status,
  input logic       out_last
);
  import swarq_pkg::*;

  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy) else $error("accepted beat did not raise busy");
  a_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_kind == KIND_DATA || out_kind == KIND_ACK ||
                   out_kind == KIND_STATUS)) else $error("bad result kind");
  a_data_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_kind == KIND_DATA) |-> (out_status == ST_OK))
    else $error("data beat with error status");
  a_reset: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result after reset");
endmodule

bind sliding_window_arq_endpoint swarq_checker u_chk (.*);

// ===== bench/sliding_window_arq_endpoint_tb.sv =====
// Self-checking bench for the sliding-window ARQ endpoint: a queue-fed driver, a
// result monitor and a beat-level predictor of the send and receive windows.
// Depends on swarq_pkg and the sliding_window_arq_endpoint RTL only.
`timescale 1ns / 100ps

module sliding_window_arq_endpoint_tb;
  import swarq_pkg::*;

  localparam int WIN = WINDOW_DEF;
  localparam int SQ_DEPTH = SEND_DEPTH_DEF;
  localparam int LIMIT = 400000;
  localparam int SETTLE = 2 * WIN + 2 + 16;

  typedef struct {
    logic [2:0] op;
    logic [7:0] frame_seq;
    logic [7:0] acked_upto;
    logic [7:0] adv_window;
  } beat_t;

  typedef struct {
    logic [1:0] kind;
    logic [7:0] tx_seq;
    logic [3:0] slot;
    logic [7:0] ack_last;
    logic [4:0] ack_window;
    logic [3:0] buf_idx;
    logic [2:0] status;
    logic       last;
  } frame_out_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [2:0] in_op = '0;
  logic [7:0] in_frame_seq = '0;
  logic [7:0] in_acked_upto = '0;
  logic [7:0] in_advertised_window = '0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [7:0] cfg_data = '0;
  logic out_valid;
  logic [1:0] out_kind;
  logic [7:0] out_tx_seq;
  logic [3:0] out_slot;
  logic [7:0] out_ack_last;
  logic [4:0] out_ack_window;
  logic [3:0] out_buffer_index;
  logic [2:0] out_status;
  logic out_last;

  sliding_window_arq_endpoint dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_op(in_op), .in_frame_seq(in_frame_seq), .in_acked_upto(in_acked_upto),
    .in_advertised_window(in_advertised_window),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .out_valid(out_valid), .out_kind(out_kind), .out_tx_seq(out_tx_seq),
    .out_slot(out_slot), .out_ack_last(out_ack_last),
    .out_ack_window(out_ack_window), .out_buffer_index(out_buffer_index),
    .out_status(out_status), .out_last(out_last)
  );

  always #1 clk = ~clk;

  // Endpoint state as the predictor sees it.
  logic [7:0]  rto = TIMEOUT_RESET;
  logic [7:0]  rx_expected = 8'd1;
  int          rx_fill = 0;
  logic        rx_full_seen = 1'b0;
  logic [7:0]  tx_base = 8'd1;
  logic [7:0]  tx_next = 8'd1;
  int          peer_win = WIN;
  logic [7:0]  slot_seq [WIN];
  logic        slot_sent [WIN];
  logic        slot_acked [WIN];
  logic [15:0] slot_time [WIN];
  logic [15:0] ticks = '0;
  int          sq_fill = 0;
  logic [3:0]  sq_head = '0;

  beat_t      op_backlog[$];
  frame_out_t expected_frames[$];
  beat_t      held;
  logic       holding = 1'b0;
  int         idle_pct = 0;
  int         errors = 0;
  int         beats_in = 0;
  int         frames_checked = 0;
  int         cycles = 0;

  initial begin
    for (int j = 0; j < WIN; j++) begin
      slot_seq[j] = '0;
      slot_sent[j] = 1'b0;
      slot_acked[j] = 1'b0;
      slot_time[j] = '0;
    end
  end

  task automatic expect_frame(logic [1:0] kind, logic [7:0] seq, logic [3:0] slot,
                              logic [7:0] alast, logic [4:0] awin, logic [3:0] bidx,
                              logic [2:0] st);
    frame_out_t f;
    f = '{kind, seq, slot, alast, awin, bidx, st, 1'b0};
    expected_frames.push_back(f);
  endtask

  task automatic predict_endpoint(beat_t b);
    int n0;
    int best;
    int free_slot;
    logic found;
    logic [7:0] outstanding;
    logic [7:0] upto;
    logic [7:0] d;
    frame_out_t f;
    n0 = expected_frames.size();
    case (b.op)
      OP_DATA: begin
        if (b.frame_seq != rx_expected) begin
          expect_frame(KIND_STATUS, 0, 0, 0, 0, 0, ST_ORDER);
        end else if (rx_fill >= WIN) begin
          rx_full_seen = 1'b1;
          expect_frame(KIND_STATUS, 0, 0, 0, 0, 0, ST_RXFULL);
        end else begin
          expect_frame(KIND_ACK, 0, 0, rx_expected, 5'(WIN - rx_fill - 1), 4'(rx_fill), ST_OK);
          rx_fill++;
          rx_expected++;
        end
      end
      OP_ACK: begin
        outstanding = tx_next - tx_base;
        upto = b.acked_upto + 8'd1 - tx_base;
        peer_win = (b.adv_window > WIN) ? WIN : int'(b.adv_window);
        if (upto <= outstanding) begin
          for (int j = 0; j < WIN; j++) begin
            d = slot_seq[j] - tx_base;
            if (slot_sent[j] && !slot_acked[j] && d < upto && d < outstanding)
              slot_acked[j] = 1'b1;
          end
        end
        found = 1'b0;
        best = 0;
        for (int j = 0; j < WIN; j++) begin
          d = slot_seq[j] - tx_base;
          if (slot_sent[j] && !slot_acked[j] && d < outstanding && (!found || d < best)) begin
            found = 1'b1;
            best = d;
          end
        end
        tx_base = found ? tx_base + 8'(best) : tx_next;
        expect_frame(KIND_STATUS, 0, 0, 0, 0, 0, ST_OK);
      end
      OP_TICK: begin
        ticks++;
        for (int j = 0; j < WIN; j++) begin
          if (slot_sent[j] && !slot_acked[j] && 16'(ticks - slot_time[j]) >= rto) begin
            slot_time[j] = ticks;
            expect_frame(KIND_DATA, slot_seq[j], 4'(j), 0, 0, 0, ST_OK);
          end
        end
        while (int'(8'(tx_next - tx_base)) < peer_win && sq_fill > 0) begin
          free_slot = -1;
          for (int j = WIN - 1; j >= 0; j--)
            if (!slot_sent[j] || slot_acked[j]) free_slot = j;
          if (free_slot < 0) break;
          slot_seq[free_slot] = tx_next;
          slot_sent[free_slot] = 1'b1;
          slot_acked[free_slot] = 1'b0;
          slot_time[free_slot] = ticks;
          expect_frame(KIND_DATA, tx_next, 4'(free_slot), 0, 0, sq_head, ST_OK);
          sq_head++;
          sq_fill--;
          tx_next++;
        end
        if (expected_frames.size() == n0)
          expect_frame(KIND_STATUS, 0, 0, 0, 0, 0, ST_IDLE);
      end
      OP_ENQ: begin
        if (sq_fill >= SQ_DEPTH) begin
          expect_frame(KIND_STATUS, 0, 0, 0, 0, 0, ST_TXFULL);
        end else begin
          expect_frame(KIND_STATUS, 0, 0, 0, 0, 4'(sq_head + sq_fill), ST_OK);
          sq_fill++;
        end
      end
      OP_CONSUME: begin
        if (rx_fill == 0) begin
          expect_frame(KIND_STATUS, 0, 0, 0, 0, 0, ST_RXEMPTY);
        end else begin
          rx_fill--;
          expect_frame(KIND_STATUS, 0, 0, 0, 0, 0, ST_OK);
          if (rx_full_seen && rx_fill < WIN) begin
            rx_full_seen = 1'b0;
            expect_frame(KIND_ACK, 0, 0, rx_expected - 8'd1, 5'(WIN - rx_fill), 0, ST_OK);
          end
        end
      end
      default: expect_frame(KIND_STATUS, 0, 0, 0, 0, 0, ST_IDLE);
    endcase
    f = expected_frames[$];
    f.last = 1'b1;
    expected_frames[$] = f;
  endtask

  task automatic report_mismatch(string what, int got, int want);
    $display("MISMATCH %s: got %0d expected %0d (beat %0d)", what, got, want, frames_checked);
    errors++;
  endtask

  // Driver: holds a beat on the input ports until start and not busy meet.
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        predict_endpoint(held);
        beats_in++;
        holding = 1'b0;
      end
      if (!holding && op_backlog.size() > 0 && $urandom_range(99) >= idle_pct) begin
        held = op_backlog.pop_front();
        holding = 1'b1;
        in_op <= held.op;
        in_frame_seq <= held.frame_seq;
        in_acked_upto <= held.acked_upto;
        in_advertised_window <= held.adv_window;
      end
      start <= holding;
    end
  end

  // Monitor: every strobed result is checked against the oldest prediction.
  always @(posedge clk) begin
    frame_out_t w;
    if (rst_n && out_valid) begin
      if (expected_frames.size() == 0) begin
        $display("MISMATCH unexpected result, kind %0d status %0d", out_kind, out_status);
        errors++;
      end else begin
        w = expected_frames.pop_front();
        if (out_kind !== w.kind) report_mismatch("kind", out_kind, w.kind);
        if (out_tx_seq !== w.tx_seq) report_mismatch("tx_seq", out_tx_seq, w.tx_seq);
        if (out_slot !== w.slot) report_mismatch("slot", out_slot, w.slot);
        if (out_ack_last !== w.ack_last) report_mismatch("ack_last", out_ack_last, w.ack_last);
        if (out_ack_window !== w.ack_window)
          report_mismatch("ack_window", out_ack_window, w.ack_window);
        if (out_buffer_index !== w.buf_idx)
          report_mismatch("buffer_index", out_buffer_index, w.buf_idx);
        if (out_status !== w.status) report_mismatch("status", out_status, w.status);
        if (out_last !== w.last) report_mismatch("last", out_last, w.last);
        frames_checked++;
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("Timeout with %0d results still expected.", expected_frames.size());
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic push_beat(logic [2:0] op, logic [7:0] fs, logic [7:0] au, logic [7:0] aw);
    beat_t b;
    b = '{op, fs, au, aw};
    op_backlog.push_back(b);
  endtask

  task automatic drain;
    while (op_backlog.size() != 0 || holding || expected_frames.size() != 0)
      @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_timeout(logic [7:0] v);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    rto = v;
  endtask

  task automatic random_phase(int count);
    int pick;
    logic [7:0] fs;
    logic [7:0] au;
    logic [7:0] aw;
    logic [2:0] op;
    for (int i = 0; i < count; i++) begin
      while (op_backlog.size() != 0) @(negedge clk);
      pick = $urandom_range(99);
      fs = ($urandom_range(9) < 8) ? rx_expected : 8'($urandom_range(255));
      if ($urandom_range(9) < 8)
        au = tx_base - 8'd1 + 8'($urandom_range(int'(8'(tx_next - tx_base))));
      else
        au = 8'($urandom_range(255));
      case ($urandom_range(9))
        0, 1: aw = 8'd0;
        2: aw = 8'($urandom_range(255));
        default: aw = 8'($urandom_range(WIN + 2));
      endcase
      if (pick < 20) op = OP_DATA;
      else if (pick < 38) op = OP_ACK;
      else if (pick < 63) op = OP_TICK;
      else if (pick < 87) op = OP_ENQ;
      else op = OP_CONSUME;
      push_beat(op, fs, au, aw);
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    idle_pct = 27;
    push_beat(OP_ENQ, 8'd0, 8'd0, 8'd0);
    push_beat(OP_ENQ, 8'd255, 8'd255, 8'd255);
    push_beat(OP_TICK, 8'd0, 8'd0, 8'd0);
    push_beat(OP_ACK, 8'd0, 8'd1, 8'd255);
    push_beat(OP_TICK, 8'd0, 8'd0, 8'd0);
    push_beat(OP_TICK, 8'd0, 8'd0, 8'd0);
    push_beat(OP_TICK, 8'd0, 8'd0, 8'd0);
    push_beat(OP_DATA, 8'd1, 8'd0, 8'd0);
    push_beat(OP_DATA, 8'd0, 8'd0, 8'd0);
    push_beat(OP_DATA, 8'd255, 8'd0, 8'd0);
    push_beat(OP_DATA, 8'd2, 8'd0, 8'd0);
    push_beat(OP_CONSUME, 8'd0, 8'd0, 8'd0);
    push_beat(OP_CONSUME, 8'd0, 8'd0, 8'd0);
    push_beat(OP_CONSUME, 8'd0, 8'd0, 8'd0);
    push_beat(OP_ACK, 8'd0, 8'd200, 8'd0);
    push_beat(OP_ENQ, 8'd0, 8'd0, 8'd0);
    push_beat(OP_TICK, 8'd0, 8'd0, 8'd0);
    push_beat(OP_ACK, 8'd0, 8'd2, 8'd10);
    push_beat(OP_TICK, 8'd0, 8'd0, 8'd0);
    push_beat(OP_ACK, 8'd0, 8'd3, 8'd11);
    push_beat(OP_TICK, 8'd0, 8'd0, 8'd0);
    drain();

    write_timeout(8'd1);
    random_phase(83);
    drain();

    idle_pct = 65;
    write_timeout(8'd255);
    random_phase(83);
    drain();

    idle_pct = 0;
    write_timeout(8'd3);
    random_phase(83);
    drain();

    $display("Covered %0d input beats and %0d checked results across timeouts 2, 1, 255, 3,",
             beats_in, frames_checked);
    $display("with sender gaps of 27, 65 and 0 percent and full drains between phases.");
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule
